// ----- rtl/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and types for the packet fragment reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  // message buffer
  localparam int BUF_BYTES = 1024;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int OFF_W     = BUF_AW + 1;      // fill offset can hold BUF_BYTES

  // item field widths
  localparam int IDX_W     = 10;
  localparam int LEN_W     = 11;

  // header layout
  localparam int HDR_BYTES      = 4;
  localparam int FLAG_START_BIT = 7;
  localparam int FLAG_END_BIT   = 6;
  localparam int SEQ_LSB        = 4;

  // internal queues
  localparam int FQ_DEPTH  = 4;
  localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W  = FQ_PTR_W + 1;

  typedef logic [BUF_AW-1:0] addr_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [1:0]        seq_t;

  typedef enum logic [2:0] {
    ST_KEPT     = 3'd0,   // also "no fault pending" in the fault register
    ST_DONE     = 3'd1,
    ST_SHORT    = 3'd2,
    ST_NO_MSG   = 3'd3,
    ST_SEQ_ERR  = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_READ     = 3'd6
  } status_t;

  // one entry of the command queue and of the result queue
  typedef struct packed {
    logic       wr;       // write data into buffer at addr
    logic       rd;       // read buffer at addr (in range)
    logic       rpt;      // produces a result
    addr_t      addr;
    logic [7:0] data;     // write data, or read data in the result queue
    status_t    status;
    logic [7:0] hdr_ver;
    logic [7:0] dst_id;
    logic [7:0] src_id;
    logic [7:0] flags;
    len_t       len;
  } pfr_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/pfr_fifo.sv -----
// ----------------------------------------------------------------------------
// pfr_fifo
// Small register queue for commands and results, with fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire pfr_pkg::pfr_cmd_t              din,
  output logic                                full,
  input  wire logic                           pop,
  output pfr_pkg::pfr_cmd_t                   dout,
  output logic                                empty,
  output logic [pfr_pkg::FQ_CNT_W-1:0]        count
);

  pfr_pkg::pfr_cmd_t                 slot_r [pfr_pkg::FQ_DEPTH];
  logic [pfr_pkg::FQ_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pfr_pkg::FQ_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pfr_pkg::FQ_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              do_push, do_pop;

  assign full    = (cnt_r == pfr_pkg::FQ_CNT_W'(pfr_pkg::FQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfr_front.sv -----
// ----------------------------------------------------------------------------
// pfr_front
// Packet parser: tracks header, sequence and fill state, emits buffer
// writes, reads and status reports as commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic                          in_action,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last_of_packet,
  input  wire logic [pfr_pkg::IDX_W-1:0]     in_read_index,
  output logic                               cmd_push,
  output pfr_pkg::pfr_cmd_t                  cmd
);

  pfr_pkg::off_t     fill_r, fill_nxt;
  pfr_pkg::seq_t     exp_r, exp_nxt;
  logic              open_r, open_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [7:0]        hdr_r [pfr_pkg::HDR_BYTES];
  logic [7:0]        hdr_nxt [pfr_pkg::HDR_BYTES];
  pfr_pkg::status_t  fault_r, fault_nxt;

  always_comb begin
    pfr_pkg::seq_t seq;
    logic          short_pkt;

    seq       = in_data_byte[pfr_pkg::SEQ_LSB +: 2];
    short_pkt = 1'b0;
    fill_nxt  = fill_r;
    exp_nxt   = exp_r;
    open_nxt  = open_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    fault_nxt = fault_r;
    cmd       = '0;

    if (accept) begin
      if (in_action) begin
        cmd.rpt    = 1'b1;
        cmd.status = pfr_pkg::ST_READ;
        cmd.addr   = pfr_pkg::addr_t'(in_read_index);
        cmd.rd     = (32'(in_read_index) < 32'(pfr_pkg::BUF_BYTES));
      end else begin
        if (pos_r < 3'(pfr_pkg::HDR_BYTES)) begin
          hdr_nxt[pos_r[1:0]] = in_data_byte;
          if (pos_r == 3'(pfr_pkg::HDR_BYTES - 1)) begin
            // flags byte: judge the header
            if (in_data_byte[pfr_pkg::FLAG_START_BIT]) begin
              fill_nxt = '0;
              open_nxt = 1'b1;
              exp_nxt  = seq;
            end
            if (!open_nxt) begin
              fault_nxt = pfr_pkg::ST_NO_MSG;
            end else if (seq != exp_nxt) begin
              fill_nxt  = '0;
              exp_nxt   = '0;
              open_nxt  = 1'b0;
              fault_nxt = pfr_pkg::ST_SEQ_ERR;
            end
            pos_nxt = pos_r + 3'd1;
          end else if (in_last_of_packet) begin
            pos_nxt    = '0;
            short_pkt  = 1'b1;
            cmd.rpt    = 1'b1;
            cmd.status = pfr_pkg::ST_SHORT;
          end else begin
            pos_nxt = pos_r + 3'd1;
          end
        end else if (fault_r == pfr_pkg::ST_KEPT) begin
          if (fill_r >= pfr_pkg::off_t'(pfr_pkg::BUF_BYTES)) begin
            fill_nxt  = '0;
            exp_nxt   = '0;
            open_nxt  = 1'b0;
            fault_nxt = pfr_pkg::ST_OVERFLOW;
          end else begin
            cmd.wr   = 1'b1;
            cmd.addr = pfr_pkg::addr_t'(fill_r);
            cmd.data = in_data_byte;
            fill_nxt = fill_r + 1'b1;
          end
        end

        if (in_last_of_packet && !short_pkt) begin
          pos_nxt = '0;
          cmd.rpt = 1'b1;
          if (fault_nxt != pfr_pkg::ST_KEPT) begin
            cmd.status = fault_nxt;
            fault_nxt  = pfr_pkg::ST_KEPT;
          end else begin
            exp_nxt = exp_nxt + 2'd1;
            if (hdr_nxt[pfr_pkg::HDR_BYTES-1][pfr_pkg::FLAG_END_BIT]) begin
              cmd.status  = pfr_pkg::ST_DONE;
              cmd.hdr_ver = hdr_nxt[0];
              cmd.dst_id  = hdr_nxt[1];
              cmd.src_id  = hdr_nxt[2];
              cmd.flags   = hdr_nxt[3];
              cmd.len     = pfr_pkg::len_t'(fill_nxt);
              open_nxt    = 1'b0;
              fill_nxt    = '0;
            end else begin
              cmd.status = pfr_pkg::ST_KEPT;
            end
          end
        end
      end
    end

    cmd_push = cmd.wr || cmd.rpt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      exp_r   <= '0;
      open_r  <= 1'b0;
      pos_r   <= '0;
      fault_r <= pfr_pkg::ST_KEPT;
      for (int i = 0; i < pfr_pkg::HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      fill_r  <= fill_nxt;
      exp_r   <= exp_nxt;
      open_r  <= open_nxt;
      pos_r   <= pos_nxt;
      fault_r <= fault_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfr_back.sv -----
// ----------------------------------------------------------------------------
// pfr_back
// Executes commands: message buffer writes and reads, result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_empty,
  input  wire pfr_pkg::pfr_cmd_t             cmd,
  output logic                               cmd_pop,
  input  wire logic [pfr_pkg::FQ_CNT_W-1:0]  res_count,
  output logic                               res_push,
  output pfr_pkg::pfr_cmd_t                  res_item
);

  logic [7:0]         buf_mem [pfr_pkg::BUF_BYTES];
  logic [7:0]         rd_data_r;
  pfr_pkg::pfr_cmd_t  stage_r;
  logic               stage_vld_r;
  logic               room;
  logic               issue;

  // reserve a result slot for the entry already in the stage register
  assign room  = stage_vld_r ?
                 (res_count < pfr_pkg::FQ_CNT_W'(pfr_pkg::FQ_DEPTH - 1)) :
                 (res_count < pfr_pkg::FQ_CNT_W'(pfr_pkg::FQ_DEPTH));
  assign issue   = !cmd_empty && (!cmd.rpt || room);
  assign cmd_pop = issue;

  always_ff @(posedge clk) begin
    if (issue && cmd.wr) begin
      buf_mem[cmd.addr] <= cmd.data;
    end
    if (issue && cmd.rd) begin
      rd_data_r <= buf_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      stage_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= issue && cmd.rpt;
    end
  end

  always_comb begin
    res_push      = stage_vld_r;
    res_item      = stage_r;
    res_item.data = stage_r.rd ? rd_data_r : 8'd0;
  end

endmodule

`default_nettype wire

// ----- rtl/packet_fragment_reassembler.sv -----
// ----------------------------------------------------------------------------
// packet_fragment_reassembler
// Receive-side reassembly of fragmented transport packets into a message
// buffer, with per-packet status and buffer read-back.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | transfer when
//   --------+------------------------------+---------------------------
//   input   | in_push / in_full, in_*      | in_push && !in_full
//   result  | out_empty / out_pop, out_*   | out_pop && !out_empty
//
// One item per cycle sustained while in_full is low: the front parser updates
// its state in the accept cycle and queues a command; the back executes one
// command a cycle, holding a report command until a result slot is free, on
// the single-port buffer (1024 x 8) and stages results through a 4-entry
// result queue. A result passes through the command queue, the stage register
// and the result queue before it can be popped. Reset is synchronous; the
// buffer is not cleared (unwritten bytes read as don't-care). in_full rises only
// when the command queue backs up, which happens when the result side stalls.
//
`default_nettype none

module packet_fragment_reassembler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_action,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last_of_packet,
  input  wire logic [pfr_pkg::IDX_W-1:0]     in_read_index,
  // result channel
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [2:0]                         out_status,
  output logic [7:0]                         out_header_version,
  output logic [7:0]                         out_destination_id,
  output logic [7:0]                         out_source_id,
  output logic [7:0]                         out_flag_bits,
  output logic [pfr_pkg::LEN_W-1:0]          out_message_length,
  output logic [7:0]                         out_read_data
);

  logic                              accept;
  // front -> command queue
  logic                              cmd_push;
  pfr_pkg::pfr_cmd_t                 cmd_in;
  // command queue -> back
  pfr_pkg::pfr_cmd_t                 cmd_head;
  logic                              cmd_empty;
  logic                              cmd_pop;
  logic [pfr_pkg::FQ_CNT_W-1:0]      cmd_count;
  // back -> result queue
  logic                              res_push;
  pfr_pkg::pfr_cmd_t                 res_in;
  logic                              res_full;
  logic [pfr_pkg::FQ_CNT_W-1:0]      res_count;
  pfr_pkg::pfr_cmd_t                 res_head;

  assign accept = in_push && !in_full;

  // Front: header tracking, sequence checks, fill offset, status decisions.
  pfr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_action         (in_action),
    .in_data_byte      (in_data_byte),
    .in_last_of_packet (in_last_of_packet),
    .in_read_index     (in_read_index),
    .cmd_push          (cmd_push),
    .cmd               (cmd_in)
  );

  // Decoupling queue; its full flag is the input backpressure.
  pfr_fifo u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  // Back: buffer access and result staging, issues reports only with a free slot.
  pfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  // Result queue seen directly on the output ports.
  pfr_fifo u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_head),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_status         = res_head.status;
  assign out_header_version = res_head.hdr_ver;
  assign out_destination_id = res_head.dst_id;
  assign out_source_id      = res_head.src_id;
  assign out_flag_bits      = res_head.flags;
  assign out_message_length = res_head.len;
  assign out_read_data      = res_head.data;

`ifndef NO_ASSERTIONS
  // the back's slot reservation must keep the result queue from overflowing
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result queue overflow");

  // in_full can only reflect a command queue that is really at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> (cmd_count == pfr_pkg::FQ_CNT_W'(pfr_pkg::FQ_DEPTH)))
    else $error("full flag without full command queue");

  // header and length only carried on a completed message
  a_hdr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != pfr_pkg::ST_DONE) |->
      (out_message_length == '0 && out_header_version == '0 &&
       out_flag_bits == '0))
    else $error("header fields on non-complete status");

  // read data only carried on a read result
  a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != pfr_pkg::ST_READ) |-> (out_read_data == '0))
    else $error("read data on non-read status");
`endif

endmodule

`default_nettype wire
